// ===== hdl/imu_bpfe_pkg.sv =====
package imu_bpfe_pkg;

  // packet field counts and group positions
  localparam int unsigned NUM_GROUPS = 7;
  localparam int unsigned NUM_FIELDS = 23;
  localparam int unsigned IMU_FIELDS = 12;
  localparam int unsigned INS_FIELDS = 11;
  localparam logic [2:0]  IMU_GROUP  = 3'd2;
  localparam logic [2:0]  INS_GROUP  = 3'd5;
  localparam logic [2:0]  NO_GROUP   = 3'd7;
  localparam logic [4:0]  NO_FIELD   = 5'd23;
  localparam logic [7:0]  SYNC_RESET = 8'hFA;

  // result status codes
  localparam logic STATUS_DATA = 1'b0;
  localparam logic STATUS_SYNC_ERR = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_GROUP   = 3'd1,
    PH_MASK_LO = 3'd2,
    PH_MASK_HI = 3'd3,
    PH_DATA    = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  typedef struct packed {
    logic       status;
    logic [4:0] field_id;
    logic [4:0] byte_pos;
    logic [7:0] payload_byte;
    logic       field_end;
  } result_t;

  // fixed byte length of each global field
  function automatic logic [4:0] field_len(input logic [4:0] f);
    logic [4:0] len;
    case (f)
      5'd0:    len = 5'd0;
      5'd1:    len = 5'd12;
      5'd2:    len = 5'd12;
      5'd3:    len = 5'd12;
      5'd4:    len = 5'd4;
      5'd5:    len = 5'd4;
      5'd6:    len = 5'd16;
      5'd7:    len = 5'd12;
      5'd8:    len = 5'd12;
      5'd9:    len = 5'd12;
      5'd10:   len = 5'd12;
      5'd11:   len = 5'd2;
      5'd12:   len = 5'd2;
      5'd13:   len = 5'd24;
      5'd14:   len = 5'd24;
      5'd15:   len = 5'd12;
      5'd16:   len = 5'd12;
      5'd17:   len = 5'd12;
      5'd18:   len = 5'd12;
      5'd19:   len = 5'd12;
      5'd20:   len = 5'd12;
      5'd21:   len = 5'd4;
      5'd22:   len = 5'd4;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // lowest present group at or above from, NO_GROUP if none
  function automatic logic [2:0] next_group(input logic [6:0] bits, input logic [2:0] from);
    logic [2:0] g;
    logic       found;
    g = NO_GROUP;
    found = 1'b0;
    for (int i = 0; i < NUM_GROUPS; i++) begin
      if (!found && bits[i] && (3'(i) >= from)) begin
        g = 3'(i);
        found = 1'b1;
      end
    end
    return g;
  endfunction

  // lowest selected nonempty field at or above from, NO_FIELD if none
  function automatic logic [4:0] next_field(input logic [NUM_FIELDS-1:0] sel,
                                            input logic [4:0] from);
    logic [4:0] f;
    logic       found;
    f = NO_FIELD;
    found = 1'b0;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      if (!found && sel[i] && (field_len(5'(i)) != 5'd0) && (5'(i) >= from)) begin
        f = 5'(i);
        found = 1'b1;
      end
    end
    return f;
  endfunction

endpackage

// ===== hdl/imu_bpfe_in_if.sv =====
interface imu_bpfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       packet_start;

  modport source(output valid, output rx_byte, output packet_start, input ready);
  modport sink(input valid, input rx_byte, input packet_start, output ready);
endinterface

// ===== hdl/imu_bpfe_out_if.sv =====
interface imu_bpfe_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [4:0] field_id;
  logic [4:0] byte_pos;
  logic [7:0] payload_byte;
  logic       field_end;

  modport source(output valid, output status, output field_id, output byte_pos,
                 output payload_byte, output field_end, input ready);
  modport sink(input valid, input status, input field_id, input byte_pos,
               input payload_byte, input field_end, output ready);
endinterface

// ===== hdl/imu_bpfe_parse.sv =====
module imu_bpfe_parse
  import imu_bpfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] sync_value,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  input  logic       packet_start,
  output logic       res_valid,
  output result_t    res
);

  phase_t                 phase, phase_next;
  logic [6:0]             group_bits, group_bits_next;
  logic [2:0]             masks_remaining, masks_remaining_next;
  logic [2:0]             mask_group_pos, mask_group_pos_next;
  logic [7:0]             mask_low_byte, mask_low_byte_next;
  logic [IMU_FIELDS-1:0]  imu_field_mask, imu_field_mask_next;
  logic [INS_FIELDS-1:0]  ins_field_mask, ins_field_mask_next;
  logic [4:0]             current_field, current_field_next;
  logic [4:0]             byte_counter, byte_counter_next;

  logic                   enter;
  logic [2:0]             pop;
  logic [2:0]             rem_dec;
  logic [2:0]             ng;
  logic [4:0]             cur_f;
  logic [4:0]             len;
  logic                   last;
  logic [4:0]             nf;
  logic [4:0]             first_f;
  logic [15:0]            mask_word;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      group_bits      <= '0;
      masks_remaining <= '0;
      mask_group_pos  <= '0;
      mask_low_byte   <= '0;
      imu_field_mask  <= '0;
      ins_field_mask  <= '0;
      current_field   <= '0;
      byte_counter    <= '0;
    end else begin
      phase           <= phase_next;
      group_bits      <= group_bits_next;
      masks_remaining <= masks_remaining_next;
      mask_group_pos  <= mask_group_pos_next;
      mask_low_byte   <= mask_low_byte_next;
      imu_field_mask  <= imu_field_mask_next;
      ins_field_mask  <= ins_field_mask_next;
      current_field   <= current_field_next;
      byte_counter    <= byte_counter_next;
    end
  end

  // per-byte parse step
  always_comb begin
    phase_next           = phase;
    group_bits_next      = group_bits;
    masks_remaining_next = masks_remaining;
    mask_group_pos_next  = mask_group_pos;
    mask_low_byte_next   = mask_low_byte;
    imu_field_mask_next  = imu_field_mask;
    ins_field_mask_next  = ins_field_mask;
    current_field_next   = current_field;
    byte_counter_next    = byte_counter;
    enter                = 1'b0;
    res_valid            = 1'b0;
    res                  = '0;
    res.payload_byte     = rx_byte;

    pop       = 3'(rx_byte[0]) + 3'(rx_byte[1]) + 3'(rx_byte[2]) + 3'(rx_byte[3])
              + 3'(rx_byte[4]) + 3'(rx_byte[5]) + 3'(rx_byte[6]);
    rem_dec   = (masks_remaining != 3'd0) ? masks_remaining - 3'd1 : 3'd0;
    ng        = next_group(group_bits, 3'(mask_group_pos + 3'd1));
    mask_word = {rx_byte, mask_low_byte};
    cur_f     = (current_field < NO_FIELD) ? current_field : 5'd0;
    len       = field_len(cur_f);
    last      = ({1'b0, byte_counter} + 6'd1) >= {1'b0, len};
    nf        = next_field({ins_field_mask, imu_field_mask}, 5'(cur_f + 5'd1));

    if (fire) begin
      if (packet_start) begin
        // new packet: clear and check sync
        group_bits_next      = '0;
        masks_remaining_next = '0;
        mask_group_pos_next  = '0;
        mask_low_byte_next   = '0;
        imu_field_mask_next  = '0;
        ins_field_mask_next  = '0;
        current_field_next   = '0;
        byte_counter_next    = '0;
        if (rx_byte != sync_value) begin
          phase_next = PH_DONE;
          res_valid  = 1'b1;
          res.status = STATUS_SYNC_ERR;
        end else begin
          phase_next = PH_GROUP;
        end
      end else begin
        case (phase)
          PH_GROUP: begin
            group_bits_next      = rx_byte[6:0];
            masks_remaining_next = pop;
            if (pop == 3'd0) begin
              mask_group_pos_next = '0;
              enter               = 1'b1;
            end else begin
              mask_group_pos_next = next_group(rx_byte[6:0], 3'd0);
              phase_next          = PH_MASK_LO;
            end
          end
          PH_MASK_LO: begin
            mask_low_byte_next = rx_byte;
            phase_next         = PH_MASK_HI;
          end
          PH_MASK_HI: begin
            if (mask_group_pos == IMU_GROUP) begin
              imu_field_mask_next = mask_word[IMU_FIELDS-1:0];
            end else if (mask_group_pos == INS_GROUP) begin
              ins_field_mask_next = mask_word[INS_FIELDS-1:0];
            end
            if (rem_dec == 3'd0 || mask_group_pos == 3'(NUM_GROUPS - 1) || ng == NO_GROUP) begin
              masks_remaining_next = '0;
              mask_group_pos_next  = '0;
              enter                = 1'b1;
            end else begin
              masks_remaining_next = rem_dec;
              mask_group_pos_next  = ng;
              phase_next           = PH_MASK_LO;
            end
          end
          PH_DATA: begin
            res_valid     = 1'b1;
            res.status    = STATUS_DATA;
            res.field_id  = cur_f;
            res.byte_pos  = byte_counter;
            res.field_end = last;
            if (last) begin
              byte_counter_next = '0;
              if (nf != NO_FIELD) begin
                current_field_next = nf;
              end else begin
                current_field_next = '0;
                phase_next         = PH_DONE;
              end
            end else begin
              byte_counter_next = byte_counter + 5'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end

    // first selected field once all masks are in
    first_f = next_field({ins_field_mask_next, imu_field_mask_next}, 5'd0);
    if (enter) begin
      byte_counter_next = '0;
      if (first_f != NO_FIELD) begin
        current_field_next = first_f;
        phase_next         = PH_DATA;
      end else begin
        current_field_next = '0;
        phase_next         = PH_DONE;
      end
    end
  end

endmodule

// ===== hdl/imu_bpfe_skid.sv =====
module imu_bpfe_skid
  import imu_bpfe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    res_valid,
  input  result_t res,
  output logic    space,
  output logic    out_valid,
  output result_t out_res,
  input  logic    out_ready
);

  logic    out_full;
  result_t out_data;
  logic    skid_full;
  result_t skid_data;

  // a new request is taken whenever the spare slot is empty
  assign space     = !skid_full;
  assign out_valid = out_full;
  assign out_res   = out_data;

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_full || out_ready) begin
      out_full  <= skid_full || res_valid;
      skid_full <= 1'b0;
    end else if (res_valid) begin
      skid_full <= 1'b1;
    end
  end

  // result data
  always_ff @(posedge clk) begin
    if (!out_full || out_ready) begin
      out_data <= skid_full ? skid_data : res;
    end else if (res_valid) begin
      skid_data <= res;
    end
  end

endmodule

// ===== hdl/imu_binary_packet_field_extractor.sv =====
// Byte-wise parser for binary inertial sensor packets. Each request carries one
// received byte and a packet-start flag. The first byte of a packet must match
// the programmed sync value (reset 0xFA); a mismatch gives a single error result
// and the packet is dropped. The group byte and one 16-bit mask per present
// group follow; only the imu and ins masks are kept. Every payload byte of a
// selected field then produces one result tagged with its field number (1..22),
// its byte position and a last-byte flag. Trailing bytes are dropped. One byte
// is accepted every clock cycle while the output buffer has space: the parse
// step is a single registered pass, and a two-entry output buffer lets input
// continue while a result is stalled. Results are registered in that buffer.
module imu_binary_packet_field_extractor
  import imu_bpfe_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  imu_bpfe_in_if.sink   in_ch,
  imu_bpfe_out_if.source out_ch
);

  logic [7:0] sync_value;
  logic       fire;
  logic       space;
  logic       res_valid;
  result_t    res;
  logic       out_valid;
  result_t    out_res;

  // sync value register
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= SYNC_RESET;
    end else if (cfg_we) begin
      sync_value <= cfg_wdata;
    end
  end

  assign in_ch.ready = space;
  assign fire        = in_ch.valid && space;

  imu_bpfe_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .sync_value   (sync_value),
    .fire         (fire),
    .rx_byte      (in_ch.rx_byte),
    .packet_start (in_ch.packet_start),
    .res_valid    (res_valid),
    .res          (res)
  );

  imu_bpfe_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_ready (out_ch.ready)
  );

  // result channel
  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_res.status;
  assign out_ch.field_id     = out_res.field_id;
  assign out_ch.byte_pos     = out_res.byte_pos;
  assign out_ch.payload_byte = out_res.payload_byte;
  assign out_ch.field_end    = out_res.field_end;

endmodule
